/* src/arc_pkg.sv */
// Package: shared constants for the repetition counter.
`default_nettype none
package arc_pkg;
   localparam int WINDOW_DEPTH = 64;
   localparam int SLOT_W       = $clog2(WINDOW_DEPTH);
   localparam int WSLOT_W      = SLOT_W + 1;

   localparam logic [2:0] CSR_STEP_THR  = 3'd0;
   localparam logic [2:0] CSR_HOLD_THR  = 3'd1;
   localparam logic [2:0] CSR_SWING_THR = 3'd2;
   localparam logic [2:0] CSR_MIN_SAMP  = 3'd3;
   localparam logic [2:0] CSR_WIN_LEN   = 3'd4;

   localparam logic [1:0] SLOPE_FALL    = 2'd0;
   localparam logic [1:0] SLOPE_RISE    = 2'd1;
   localparam logic [1:0] SLOPE_UNKNOWN = 2'd2;

   typedef struct packed {
      logic [15:0] rep_total;
      logic        rep_seen;
      logic [31:0] rep_frame;
   } rsp_word_type;
endpackage
`default_nettype wire

/* src/arc_if.sv */
// Interfaces: sample request channel and result channel.
`default_nettype none
interface arc_req_if;
   logic               valid;
   logic               ready;
   logic signed [15:0] accel_x;
   logic signed [15:0] accel_y;
   logic signed [15:0] accel_z;
   modport source (output valid, output accel_x, output accel_y, output accel_z,
                   input ready);
   modport sink (input valid, input accel_x, input accel_y, input accel_z,
                 output ready);
endinterface

interface arc_rsp_if;
   logic        valid;
   logic        ready;
   logic [15:0] rep_total;
   logic        rep_seen;
   logic [31:0] rep_frame;
   modport source (output valid, output rep_total, output rep_seen, output rep_frame,
                   input ready);
   modport sink (input valid, input rep_total, input rep_seen, input rep_frame,
                 output ready);
endinterface
`default_nettype wire

/* src/arc_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module arc_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output      logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule
`default_nettype wire

/* src/accel_repetition_counter.sv */
// Top level: accelerometer repetition counter with a shared iterative datapath.
// Usage:
//  - req_ch carries one three-axis sample word (accel_x/y/z, signed 16 bit).
//    A word is taken when valid and ready are high at a rising clock edge.
//  - rsp_ch returns one result word per sample: rep_total (saturating count),
//    rep_seen (this sample counted a repetition) and rep_frame (sample number
//    of the latest counted repetition).
//  - csr_wr_en/csr_index/csr_wr_data write the five thresholds; write only
//    while the block is idle. Unknown indexes are dropped.
//  - Processing: an accept step, squaring of the three axes on one shared
//    multiplier, a bit-serial square root, window update and slope tracking,
//    then loading of the result. When a repetition
//    is declared the window is compacted through the single RAM port pair,
//    each entry read and then written, followed by a closing step.
//  - One sample is in flight at a time; req ready is high only when idle.
//  - If the receiver stalls, the finished result waits in the output register
//    and the next sample may be accepted and processed; its result is held
//    back until the previous word is taken.
//  - Reset (synchronous, active high) restores all thresholds and tracker state.
//    The sample RAM is not cleared; the block does not stop an entry being read before it is written.
`default_nettype none
module accel_repetition_counter (
   input  wire logic             clock,
   input  wire logic             reset,
   arc_req_if.sink               req_ch,
   arc_rsp_if.source             rsp_ch,
   input  wire logic             csr_wr_en,
   input  wire logic [2:0]       csr_index,
   input  wire logic [15:0]      csr_wr_data
);
   import arc_pkg::*;

   localparam logic [3:0] ST_IDLE   = 4'd0;
   localparam logic [3:0] ST_MUL    = 4'd1;
   localparam logic [3:0] ST_SQRT   = 4'd2;
   localparam logic [3:0] ST_READ   = 4'd3;
   localparam logic [3:0] ST_UPDATE = 4'd4;
   localparam logic [3:0] ST_HOLD   = 4'd5;
   localparam logic [3:0] ST_SLOPE  = 4'd6;
   localparam logic [3:0] ST_CP_RD  = 4'd7;
   localparam logic [3:0] ST_CP_WR  = 4'd8;
   localparam logic [3:0] ST_FINISH = 4'd9;

   localparam logic [WSLOT_W-1:0] RESTART_SLOT = WSLOT_W'(7);

   // configuration
   logic [15:0] step_thr_ff, hold_thr_ff, swing_thr_ff;
   logic [7:0]  min_samp_ff;
   logic [2:0]  win_len_ff;

   // sequencer and datapath
   logic [3:0]         state_ff, state_in;
   logic [3:0]         cnt_ff, cnt_in;
   logic [15:0]        ax_ff, ay_ff, az_ff;
   logic [31:0]        prod_ff, prod_in;
   logic [31:0]        acc_ff, acc_in;
   logic [31:0]        root_ff, root_in;
   logic [31:0]        bit_ff, bit_in;
   logic [15:0]        mag_ff;

   // tracker state
   logic [WSLOT_W-1:0] ws_ff, ws_in;
   logic [7:0]         ss_ff, ss_in;
   logic [31:0]        sum_ff, sum_in;
   logic [31:0]        prev_ff, prev_in;
   logic [15:0]        high_ff, high_in;
   logic [15:0]        low_ff, low_in;
   logic signed [31:0] peak_ff, peak_in;
   logic signed [31:0] valley_ff, valley_in;
   logic [1:0]         mode_ff, mode_in;
   logic [15:0]        reps_ff, reps_in;
   logic [31:0]        frame_ff, frame_in;
   logic [31:0]        last_ff, last_in;
   logic               seen_ff, seen_in;
   logic [2:0]         cpi_ff, cpi_in;

   // output register
   rsp_word_type       out_ff, out_in;
   logic               ovalid_ff, ovalid_in;

   // RAM
   logic               ram_we;
   logic [SLOT_W-1:0]  ram_waddr, ram_raddr;
   logic [15:0]        ram_wdata, ram_rdata;

   // combinational helpers
   logic [15:0]        mul_op;
   logic [31:0]        trial;
   logic signed [32:0] diff;
   logic [32:0]        diff_abs;
   logic signed [33:0] nw_s, old_s, step_s, twice_mid, nw2, old2;
   logic               declare;
   logic [15:0]        swing;

   arc_ram #(.WIDTH(16), .DEPTH(WINDOW_DEPTH)) u_store (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   assign req_ch.ready     = (state_ff == ST_IDLE);
   assign rsp_ch.valid     = ovalid_ff;
   assign rsp_ch.rep_total = out_ff.rep_total;
   assign rsp_ch.rep_seen  = out_ff.rep_seen;
   assign rsp_ch.rep_frame = out_ff.rep_frame;

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         step_thr_ff  <= 16'd256;
         hold_thr_ff  <= 16'd64;
         swing_thr_ff <= 16'd512;
         min_samp_ff  <= 8'd5;
         win_len_ff   <= 3'd5;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_STEP_THR:  step_thr_ff  <= csr_wr_data;
            CSR_HOLD_THR:  hold_thr_ff  <= csr_wr_data;
            CSR_SWING_THR: swing_thr_ff <= csr_wr_data;
            CSR_MIN_SAMP:  min_samp_ff  <= csr_wr_data[7:0];
            CSR_WIN_LEN:   win_len_ff   <= csr_wr_data[2:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (cnt_ff[1:0])
         2'd0:    mul_op = ax_ff;
         2'd1:    mul_op = ay_ff;
         default: mul_op = az_ff;
      endcase
      trial    = root_ff + bit_ff;
      diff     = $signed({sum_ff[31], sum_ff}) - $signed({prev_ff[31], prev_ff});
      diff_abs = diff[32] ? 33'(-diff) : 33'(diff);
      nw_s      = 34'(signed'(sum_ff));
      old_s     = 34'(signed'(prev_ff));
      step_s    = $signed({18'd0, step_thr_ff});
      twice_mid = 34'(peak_ff) + 34'(valley_ff);
      nw2       = nw_s <<< 1;
      old2      = old_s <<< 1;
      declare   = (ss_ff > 8'd6) && (mode_ff == SLOPE_RISE) && (peak_ff > valley_ff)
                  && (nw2 > twice_mid) && (old2 < twice_mid);
      swing     = (high_ff >= low_ff) ? (high_ff - low_ff) : (low_ff - high_ff);
   end

   always_comb begin
      state_in  = state_ff;
      cnt_in    = cnt_ff;
      prod_in   = prod_ff;
      acc_in    = acc_ff;
      root_in   = root_ff;
      bit_in    = bit_ff;
      ws_in     = ws_ff;
      ss_in     = ss_ff;
      sum_in    = sum_ff;
      prev_in   = prev_ff;
      high_in   = high_ff;
      low_in    = low_ff;
      peak_in   = peak_ff;
      valley_in = valley_ff;
      mode_in   = mode_ff;
      reps_in   = reps_ff;
      frame_in  = frame_ff;
      last_in   = last_ff;
      seen_in   = seen_ff;
      cpi_in    = cpi_ff;
      out_in    = out_ff;
      ovalid_in = ovalid_ff && !rsp_ch.ready;
      ram_we    = 1'b0;
      ram_waddr = ws_ff[SLOT_W-1:0];
      ram_wdata = mag_ff;
      ram_raddr = ws_ff[SLOT_W-1:0] - SLOT_W'(win_len_ff);

      case (state_ff)
         ST_IDLE: begin
            if (req_ch.valid) begin
               frame_in = frame_ff + 32'd1;
               if (ws_ff >= WSLOT_W'(WINDOW_DEPTH)) begin
                  ws_in = RESTART_SLOT;
                  ss_in = 8'd7;
               end
               cnt_in   = 4'd0;
               acc_in   = 32'd0;
               seen_in  = 1'b0;
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            // multiply one axis, accumulate the previous product
            prod_in = {16'd0, mul_op} * {16'd0, mul_op};
            if (cnt_ff != 4'd0) begin
               acc_in = acc_ff + prod_ff;
            end
            cnt_in = cnt_ff + 4'd1;
            if (cnt_ff == 4'd3) begin
               root_in  = 32'd0;
               bit_in   = 32'h4000_0000;
               cnt_in   = 4'd0;
               state_in = ST_SQRT;
            end
         end
         ST_SQRT: begin
            // one result bit per cycle
            if (acc_ff >= trial) begin
               acc_in  = acc_ff - trial;
               root_in = (root_ff >> 1) + bit_ff;
            end else begin
               root_in = root_ff >> 1;
            end
            bit_in = bit_ff >> 2;
            cnt_in = cnt_ff + 4'd1;
            if (cnt_ff == 4'd15) begin
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            // issue read of the entry leaving the window
            state_in = ST_UPDATE;
         end
         ST_UPDATE: begin
            ram_we = 1'b1;
            if (ss_ff > min_samp_ff) begin
               prev_in = sum_ff;
               sum_in  = sum_ff - {16'd0, ram_rdata} + {16'd0, mag_ff};
            end else begin
               sum_in  = sum_ff + {16'd0, mag_ff};
            end
            if (mag_ff > high_ff) high_in = mag_ff;
            if (mag_ff < low_ff) low_in = mag_ff;
            if (ss_ff != 8'hFF) ss_in = ss_ff + 8'd1;
            ws_in    = ws_ff + WSLOT_W'(1);
            state_in = ST_HOLD;
         end
         ST_HOLD: begin
            if (diff_abs < {17'd0, hold_thr_ff}) begin
               sum_in = prev_ff;
            end
            state_in = ST_SLOPE;
         end
         ST_SLOPE: begin
            state_in = ST_FINISH;
            if (declare) begin
               if (swing > swing_thr_ff) begin
                  if (reps_ff != 16'hFFFF) reps_in = reps_ff + 16'd1;
                  last_in = frame_ff;
                  seen_in = 1'b1;
               end
               peak_in   = 32'sh8000_0000;
               valley_in = 32'sh7FFF_FFFF;
               high_in   = 16'd0;
               low_in    = 16'hFFFF;
               cpi_in    = 3'd0;
               state_in  = ST_CP_RD;
            end else if (ss_ff > 8'd6) begin
               case (mode_ff)
                  SLOPE_UNKNOWN: begin
                     if (nw_s > old_s + step_s) mode_in = SLOPE_RISE;
                     if (nw_s < old_s - step_s) mode_in = SLOPE_FALL;
                  end
                  SLOPE_RISE: begin
                     if (nw_s < old_s - step_s) begin
                        mode_in = SLOPE_FALL;
                        if ($signed(prev_ff) > peak_ff) peak_in = $signed(prev_ff);
                     end
                  end
                  SLOPE_FALL: begin
                     if (nw_s > old_s + step_s) begin
                        mode_in = SLOPE_RISE;
                        if ($signed(prev_ff) < valley_ff) valley_in = $signed(prev_ff);
                     end
                  end
                  default: ;
               endcase
            end
         end
         ST_CP_RD: begin
            // move newest entries to the front, each one read and then written
            if (cpi_ff >= win_len_ff) begin
               ws_in    = WSLOT_W'(win_len_ff);
               state_in = ST_FINISH;
            end else begin
               ram_raddr = ws_ff[SLOT_W-1:0] + SLOT_W'(cpi_ff) - SLOT_W'(win_len_ff);
               state_in  = ST_CP_WR;
            end
         end
         ST_CP_WR: begin
            ram_we    = 1'b1;
            ram_waddr = SLOT_W'(cpi_ff);
            ram_wdata = ram_rdata;
            cpi_in    = cpi_ff + 3'd1;
            state_in  = ST_CP_RD;
         end
         ST_FINISH: begin
            // hold until the output register is free
            if (!ovalid_ff || rsp_ch.ready) begin
               out_in.rep_total = reps_ff;
               out_in.rep_seen  = seen_ff;
               out_in.rep_frame = last_ff;
               ovalid_in        = 1'b1;
               state_in         = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         ws_ff     <= '0;
         ss_ff     <= 8'd0;
         sum_ff    <= 32'd0;
         prev_ff   <= 32'd0;
         high_ff   <= 16'd0;
         low_ff    <= 16'hFFFF;
         peak_ff   <= 32'sh8000_0000;
         valley_ff <= 32'sh7FFF_FFFF;
         mode_ff   <= SLOPE_UNKNOWN;
         reps_ff   <= 16'd0;
         frame_ff  <= 32'd0;
         last_ff   <= 32'd0;
         ovalid_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         ws_ff     <= ws_in;
         ss_ff     <= ss_in;
         sum_ff    <= sum_in;
         prev_ff   <= prev_in;
         high_ff   <= high_in;
         low_ff    <= low_in;
         peak_ff   <= peak_in;
         valley_ff <= valley_in;
         mode_ff   <= mode_in;
         reps_ff   <= reps_in;
         frame_ff  <= frame_in;
         last_ff   <= last_in;
         ovalid_ff <= ovalid_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff  <= cnt_in;
      prod_ff <= prod_in;
      acc_ff  <= acc_in;
      root_ff <= root_in;
      bit_ff  <= bit_in;
      seen_ff <= seen_in;
      cpi_ff  <= cpi_in;
      out_ff  <= out_in;
      if (state_ff == ST_IDLE && req_ch.valid) begin
         ax_ff <= req_ch.accel_x[15] ? 16'(-req_ch.accel_x) : req_ch.accel_x;
         ay_ff <= req_ch.accel_y[15] ? 16'(-req_ch.accel_y) : req_ch.accel_y;
         az_ff <= req_ch.accel_z[15] ? 16'(-req_ch.accel_z) : req_ch.accel_z;
      end
      if (state_ff == ST_SQRT && cnt_ff == 4'd15) begin
         mag_ff <= root_in[15:0];
      end
   end

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_ch.valid && req_ch.ready) |=> !req_ch.ready)
      else $error("accepted a second word while busy");
   a_slot_bound: assert property (@(posedge clock) disable iff (reset)
      ws_ff <= WSLOT_W'(WINDOW_DEPTH))
      else $error("write slot past buffer end");
   a_mode_legal: assert property (@(posedge clock) disable iff (reset)
      mode_ff != 2'd3)
      else $error("slope mode three reached");
   a_seen_count: assert property (@(posedge clock) disable iff (reset)
      (ovalid_ff && out_ff.rep_seen) |-> (out_ff.rep_total != 16'd0))
      else $error("repetition flagged with zero count");
endmodule
`default_nettype wire

/* sim/arc_checker.sv */
`timescale 1ns / 1ps
// Checker: watches the sample and result channels, predicts each result word and compares.
module arc_checker
   import arc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   arc_req_if          req_ch,
   arc_rsp_if          rsp_ch,
   input  logic        csr_wr_en,
   input  logic [2:0]  csr_index,
   input  logic [15:0] csr_wr_data,
   output int          error_count,
   output int          pending_count,
   output int          reps_observed
);
   logic [15:0]  step_thr, hold_thr, swing_thr;
   logic [7:0]   min_samp;
   logic [2:0]   win_len;
   logic [15:0]  mag_store [WINDOW_DEPTH];
   int           wslot, seen_cnt;
   logic [31:0]  win_sum, prev_sum;
   logic [15:0]  run_high, run_low;
   longint       peak_lvl, valley_lvl;
   logic [1:0]   slope;
   logic [15:0]  rep_count;
   logic [31:0]  frame_count, last_frame;
   rsp_word_type expected_words[$];

   function automatic logic [15:0] isqrt(longint unsigned n);
      longint unsigned root, b;
      root = 0;
      b = 64'd1 << 62;
      while (b > n) b = b >> 2;
      while (b != 0) begin
         if (n >= root + b) begin
            n = n - (root + b);
            root = (root >> 1) + b;
         end else begin
            root = root >> 1;
         end
         b = b >> 2;
      end
      return root[15:0];
   endfunction

   function automatic bit track_slope(longint nw, longint old);
      longint stp, mid2;
      stp = step_thr;
      mid2 = peak_lvl + valley_lvl;
      case (slope)
         SLOPE_UNKNOWN: begin
            if (nw > old + stp) slope = SLOPE_RISE;
            if (nw < old - stp) slope = SLOPE_FALL;
         end
         SLOPE_RISE: begin
            if (peak_lvl > valley_lvl && 2 * nw > mid2 && 2 * old < mid2) return 1'b1;
            if (nw < old - stp) begin
               slope = SLOPE_FALL;
               if (old > peak_lvl) peak_lvl = old;
            end
         end
         SLOPE_FALL: begin
            if (nw > old + stp) begin
               slope = SLOPE_RISE;
               if (old < valley_lvl) valley_lvl = old;
            end
         end
         default: ;
      endcase
      return 1'b0;
   endfunction

   function automatic rsp_word_type count_sample(logic signed [15:0] ax, logic signed [15:0] ay,
                                                 logic signed [15:0] az);
      longint       sq, d;
      logic [15:0]  mag, swing;
      bit           seen;
      rsp_word_type w;
      sq = longint'(ax) * ax + longint'(ay) * ay + longint'(az) * az;
      mag = isqrt(sq);
      seen = 1'b0;
      frame_count++;
      if (wslot >= WINDOW_DEPTH) begin
         wslot = 7;
         seen_cnt = 7;
      end
      if (seen_cnt > min_samp) begin
         prev_sum = win_sum;
         win_sum -= mag_store[(wslot + WINDOW_DEPTH - win_len) % WINDOW_DEPTH];
      end
      mag_store[wslot % WINDOW_DEPTH] = mag;
      win_sum += mag;
      d = longint'($signed(win_sum)) - longint'($signed(prev_sum));
      if (d < 0) d = -d;
      if (d < hold_thr) win_sum = prev_sum;
      if (mag > run_high) run_high = mag;
      if (mag < run_low) run_low = mag;
      if (seen_cnt < 255) seen_cnt++;
      wslot++;
      if (seen_cnt > 6 && track_slope($signed(win_sum), $signed(prev_sum))) begin
         swing = (run_high >= run_low) ? run_high - run_low : run_low - run_high;
         if (swing > swing_thr) begin
            if (rep_count != 16'hFFFF) rep_count++;
            last_frame = frame_count;
            seen = 1'b1;
         end
         // compact: move the newest window entries to the front
         for (int i = 0; i < win_len; i++)
            mag_store[i] = mag_store[(wslot + i + WINDOW_DEPTH - win_len) % WINDOW_DEPTH];
         wslot = win_len;
         peak_lvl = -64'sd2147483648;
         valley_lvl = 64'sd2147483647;
         run_high = 16'd0;
         run_low = 16'hFFFF;
      end
      w.rep_total = rep_count;
      w.rep_seen = seen;
      w.rep_frame = last_frame;
      return w;
   endfunction

   always @(posedge clock) begin
      rsp_word_type got, want;
      if (reset) begin
         step_thr = 16'd256; hold_thr = 16'd64; swing_thr = 16'd512;
         min_samp = 8'd5; win_len = 3'd5;
         wslot = 0; seen_cnt = 0; win_sum = 0; prev_sum = 0;
         run_high = 16'd0; run_low = 16'hFFFF;
         peak_lvl = -64'sd2147483648; valley_lvl = 64'sd2147483647;
         slope = SLOPE_UNKNOWN; rep_count = 0; frame_count = 0; last_frame = 0;
         expected_words.delete();
      end else begin
         if (csr_wr_en) begin
            case (csr_index)
               CSR_STEP_THR:  step_thr = csr_wr_data;
               CSR_HOLD_THR:  hold_thr = csr_wr_data;
               CSR_SWING_THR: swing_thr = csr_wr_data;
               CSR_MIN_SAMP:  min_samp = csr_wr_data[7:0];
               CSR_WIN_LEN:   win_len = csr_wr_data[2:0];
               default: ;
            endcase
         end
         if (req_ch.valid && req_ch.ready)
            expected_words.push_back(count_sample(req_ch.accel_x, req_ch.accel_y,
                                                  req_ch.accel_z));
         if (rsp_ch.valid && rsp_ch.ready) begin
            got.rep_total = rsp_ch.rep_total;
            got.rep_seen = rsp_ch.rep_seen;
            got.rep_frame = rsp_ch.rep_frame;
            if (got.rep_seen) reps_observed++;
            if (expected_words.size() == 0) begin
               error_count++;
               if (error_count <= 10)
                  $display("%t unexpected result word total=%0d seen=%0d frame=%0d",
                           $realtime, got.rep_total, got.rep_seen, got.rep_frame);
            end else begin
               want = expected_words.pop_front();
               if (got != want) begin
                  error_count++;
                  if (error_count <= 10)
                     $display("%t mismatch: expected total=%0d seen=%0d frame=%0d, got %0d %0d %0d",
                              $realtime, want.rep_total, want.rep_seen, want.rep_frame,
                              got.rep_total, got.rep_seen, got.rep_frame);
               end
            end
         end
      end
      pending_count = expected_words.size();
   end

   initial begin
      error_count = 0;
      pending_count = 0;
      reps_observed = 0;
   end
endmodule

/* sim/tb_accel_repetition_counter.sv */
`timescale 1ns / 1ps
// Testbench top: sample stimulus, threshold phases and the verdict for the repetition counter.
module tb_accel_repetition_counter;
   import arc_pkg::*;

   localparam int CYCLE_LIMIT = 1000000;
   localparam int SETTLE = 80;      // result latency plus worst-case compaction, with margin

   logic        clock;
   logic        reset;
   logic        csr_wr_en;
   logic [2:0]  csr_index;
   logic [15:0] csr_wr_data;
   int          error_count, pending_count, reps_observed;
   int          cycle_count;
   int          samples_sent;
   int          settings_used;
   int          burst_left;
   int          stall_mode;

   arc_req_if req_ch ();
   arc_rsp_if rsp_ch ();

   accel_repetition_counter dut (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_ch),
      .rsp_ch      (rsp_ch),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data)
   );

   arc_checker u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_ch        (req_ch),
      .rsp_ch        (rsp_ch),
      .csr_wr_en     (csr_wr_en),
      .csr_index     (csr_index),
      .csr_wr_data   (csr_wr_data),
      .error_count   (error_count),
      .pending_count (pending_count),
      .reps_observed (reps_observed)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Watchdog: stop a hung run.
   initial cycle_count = 0;
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   // Receiver stalls: pick a new pattern periodically, from no stall to long stalls.
   initial stall_mode = 0;
   always @(posedge clock) begin
      if (cycle_count % 300 == 0) stall_mode <= $urandom_range(0, 3);
      case (stall_mode)
         0: rsp_ch.ready <= 1'b1;
         1: rsp_ch.ready <= ($urandom_range(0, 3) != 0);
         2: rsp_ch.ready <= ($urandom_range(0, 1) != 0);
         default: rsp_ch.ready <= ($urandom_range(0, 15) == 0);
      endcase
   end

   // Present one sample word and hold it until it is taken; gaps fall between bursts.
   task automatic send_sample(logic signed [15:0] ax, logic signed [15:0] ay,
                              logic signed [15:0] az);
      int gap;
      if (burst_left == 0) begin
         gap = $urandom_range(0, 12);
         if (gap != 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 20);
      end
      req_ch.valid <= 1'b1;
      req_ch.accel_x <= ax;
      req_ch.accel_y <= ay;
      req_ch.accel_z <= az;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      burst_left--;
      samples_sent++;
   endtask

   // Drop valid, drain every expected word, then let any compaction finish.
   task automatic go_idle();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_csr(logic [2:0] idx, logic [15:0] val);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wr_data <= val;
      @(posedge clock);
   endtask

   task automatic load_thresholds(logic [15:0] stp, logic [15:0] hld, logic [15:0] swg,
                                  logic [7:0] mins, logic [2:0] wlen);
      go_idle();
      write_csr(CSR_STEP_THR, stp);
      write_csr(CSR_HOLD_THR, hld);
      write_csr(CSR_SWING_THR, swg);
      write_csr(CSR_MIN_SAMP, {8'($urandom_range(0, 255)), mins});
      write_csr(CSR_WIN_LEN, {13'($urandom_range(0, 8191)), wlen});
      // an index past the register list must be dropped
      write_csr(3'd5 + 3'($urandom_range(0, 2)), 16'($urandom_range(0, 65535)));
      csr_wr_en <= 1'b0;
      settings_used++;
   endtask

   // Periodic motion: a triangle in magnitude along x with jitter on all axes.
   task automatic send_motion(int count);
      int period, amp, base, ph, tri_pos, level;
      period = $urandom_range(6, 40);
      amp = $urandom_range(200, 12000);
      base = $urandom_range(0, 20000);
      ph = $urandom_range(0, period - 1);
      for (int k = 0; k < count; k++) begin
         ph = (ph + 1) % period;
         tri_pos = (ph < period / 2) ? ph : period - ph;
         level = base + amp * 2 * tri_pos / period + $urandom_range(0, 60);
         if (level > 32767) level = 32767;
         if ($urandom_range(0, 1)) level = -level;
         send_sample(16'(level), 16'($signed($urandom_range(0, 80)) - 40),
                     16'($signed($urandom_range(0, 80)) - 40));
      end
   endtask

   // Mostly well-formed motion with random shape, the rest full-range noise.
   task automatic run_phase(int count);
      int done;
      done = 0;
      while (done < count) begin
         if ($urandom_range(0, 9) < 8) begin
            send_motion(40);
            done += 40;
         end else begin
            repeat (10)
               send_sample(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                           16'($urandom_range(0, 65535)));
            done += 10;
         end
      end
   endtask

   initial begin
      reset = 1'b1;
      csr_wr_en = 1'b0;
      csr_index = CSR_STEP_THR;
      csr_wr_data = 16'd0;
      req_ch.valid = 1'b0;
      req_ch.accel_x = 16'sd0;
      req_ch.accel_y = 16'sd0;
      req_ch.accel_z = 16'sd0;
      rsp_ch.ready = 1'b1;
      samples_sent = 0;
      settings_used = 1;
      burst_left = 0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Fill the whole sample store under reset thresholds with a steady level so
      // no repetition compacts it; every later setting then reads written entries only.
      repeat (70) send_sample(16'sd1000, 16'sd0, 16'sd0);

      // Directed: field extremes, the largest magnitude, sign bits and a clean swing.
      send_sample(16'sh8000, 16'sh8000, 16'sh8000);
      send_sample(16'sh7FFF, 16'sh7FFF, 16'sh7FFF);
      send_sample(16'sd0, 16'sd0, 16'sd0);
      send_sample(16'sh8000, 16'sd0, 16'sh7FFF);
      send_sample(16'shFFFF, 16'sh0001, 16'shFFFF);
      send_sample(16'sh5555, 16'shAAAA, 16'sh5555);
      send_sample(16'shAAAA, 16'sh5555, 16'shAAAA);
      for (int k = 0; k < 16; k++)
         send_sample(16'((k % 8 < 4) ? 3000 + 4000 * (k % 4) : 15000 - 4000 * (k % 4)),
                     16'sd0, 16'sd0);

      run_phase(200);
      // Extremes: everything switches and counts, longest window, no hold-off.
      load_thresholds(16'd0, 16'd0, 16'd0, 8'd6, 3'd7);
      run_phase(180);
      // Extremes: nothing switches, oldest entry never subtracted, one-entry window.
      load_thresholds(16'hFFFF, 16'hFFFF, 16'hFFFF, 8'd255, 3'd1);
      run_phase(120);
      // Zero window length and no sample gate.
      load_thresholds(16'd100, 16'd10, 16'd300, 8'd0, 3'd0);
      run_phase(180);
      load_thresholds(16'd400, 16'd32, 16'd1000, 8'd0, 3'd3);
      run_phase(180);
      repeat (4) begin
         load_thresholds(16'($urandom_range(0, 3000)), 16'($urandom_range(0, 500)),
                         16'($urandom_range(0, 4000)), 8'($urandom_range(0, 12)),
                         3'($urandom_range(0, 7)));
         run_phase(150);
      end

      go_idle();
      $display("Covered %0d samples over %0d threshold settings; %0d counted repetitions seen.",
               samples_sent, settings_used, reps_observed);
      if (error_count == 0 && pending_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end
endmodule

/* files.f */
src/arc_pkg.sv
src/arc_if.sv
src/arc_ram.sv
src/accel_repetition_counter.sv
sim/arc_checker.sv
sim/tb_accel_repetition_counter.sv
